// ----- src/cnms_pkg.sv -----
// Package with shared types, constants and sequencer states of the class-wise NMS unit.
package cnms_pkg;

  localparam int unsigned MaxBoxesDef  = 64;
  localparam int unsigned LabelBitsDef = 8;
  localparam logic [15:0] IouThrReset  = 16'd29491;

  typedef struct packed {
    logic [15:0] box_x_min;
    logic [15:0] box_y_min;
    logic [15:0] box_x_max;
    logic [15:0] box_y_max;
    logic [15:0] score;
    logic [7:0]  class_label;
    logic        last_box;
  } in_t;

  typedef struct packed {
    logic [5:0] kept_index;
    logic       last_kept;
  } out_t;

  typedef struct packed {
    logic [15:0] x_min;
    logic [15:0] y_min;
    logic [15:0] x_max;
    logic [15:0] y_max;
  } box_t;

  typedef struct packed {
    logic ld_ext;
    logic ld_mul;
    logic ld_uni;
  } iou_ctl_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_SI_RD,
    ST_SI_WT,
    ST_SJ_RD,
    ST_SJ_CMP,
    ST_ORD_WR,
    ST_A_RD,
    ST_A_WT,
    ST_I_RD,
    ST_I_WT,
    ST_B_RD,
    ST_B_WT,
    ST_J_RD,
    ST_J_WT,
    ST_C1,
    ST_C2,
    ST_C3,
    ST_NEXT_B,
    ST_NEXT_A,
    ST_FLUSH
  } state_e;

endpackage

// ----- src/cnms_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module cnms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/cnms_iou.sv -----
// Staged IoU datapath that decides whether a kept box suppresses a candidate box.
module cnms_iou (
  input  logic              clk_i,
  input  cnms_pkg::iou_ctl_t ctl_i,
  input  cnms_pkg::box_t    box_a_i,
  input  cnms_pkg::box_t    box_b_i,
  input  logic [15:0]       thr_i,
  output logic              suppress_o
);

  function automatic logic [15:0] extent(input logic [15:0] lo, input logic [15:0] hi);
    return (hi > lo) ? (hi - lo) : 16'd0;
  endfunction

  logic [15:0] iw_q, ih_q, aw_q, ah_q, bw_q, bh_q;
  logic [31:0] inter_q, area_a_q, area_b_q;
  logic [32:0] uni_q;
  logic        ok_q;
  logic [15:0] ix0, iy0, ix1, iy1;
  logic [32:0] sum;
  logic [48:0] lhs, rhs;

  always_comb begin
    ix0 = (box_a_i.x_min > box_b_i.x_min) ? box_a_i.x_min : box_b_i.x_min;
    iy0 = (box_a_i.y_min > box_b_i.y_min) ? box_a_i.y_min : box_b_i.y_min;
    ix1 = (box_a_i.x_max < box_b_i.x_max) ? box_a_i.x_max : box_b_i.x_max;
    iy1 = (box_a_i.y_max < box_b_i.y_max) ? box_a_i.y_max : box_b_i.y_max;
    sum = {1'b0, area_a_q} + {1'b0, area_b_q};
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_ext) begin
      iw_q <= extent(ix0, ix1);
      ih_q <= extent(iy0, iy1);
      aw_q <= extent(box_a_i.x_min, box_a_i.x_max);
      ah_q <= extent(box_a_i.y_min, box_a_i.y_max);
      bw_q <= extent(box_b_i.x_min, box_b_i.x_max);
      bh_q <= extent(box_b_i.y_min, box_b_i.y_max);
    end
    if (ctl_i.ld_mul) begin
      inter_q  <= iw_q * ih_q;
      area_a_q <= aw_q * ah_q;
      area_b_q <= bw_q * bh_q;
    end
    if (ctl_i.ld_uni) begin
      // A union of zero or less never suppresses.
      ok_q  <= sum > {1'b0, inter_q};
      uni_q <= sum - {1'b0, inter_q};
    end
  end

  always_comb begin
    lhs = {1'b0, inter_q, 16'd0};
    rhs = {33'd0, thr_i} * {16'd0, uni_q};
    suppress_o = ok_q && (lhs > rhs);
  end

endmodule

// ----- src/classwise_nms_unit.sv -----
// Top level of the class-wise non-maximum suppression unit with its sequencer.
//
// Boxes are loaded one beat at a time: a beat on in_i is taken at a rising edge
// where start is high and busy is low. Boxes beyond MAX_BOXES are dropped; a
// beat with last_box set still ends the set. After the last beat busy rises and
// the sequencer ranks the n loaded boxes by counting, for each box, how many
// boxes rank before it. It then runs greedy suppression: each order slot is
// read, and for each kept box every later slot is skipped or, if it has the
// same class, given an IoU test, on one staged IoU unit and single-port-read
// memories. A flush state ends the set. Each kept index appears on result_o
// for one cycle with result_valid_o high, one beat per kept box, the final one
// marked by last_kept; the receiver cannot stall and every beat is taken in the
// cycle it is shown. When the set is done busy falls and the next set may be
// loaded. cfg_we_i writes the IoU threshold; the user must write it only while
// the block is idle, which the block itself does not enforce. Reset empties
// the store, clears busy and sets the threshold to its default; no clearing
// pass is needed.
module classwise_nms_unit #(
  parameter int unsigned MAX_BOXES  = cnms_pkg::MaxBoxesDef,
  parameter int unsigned LABEL_BITS = cnms_pkg::LabelBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  cnms_pkg::in_t  in_i,
  output logic           result_valid_o,
  output cnms_pkg::out_t result_o,
  input  logic           cfg_we_i,
  input  logic [15:0]    cfg_wdata_i
);

  localparam int unsigned IW = $clog2(MAX_BOXES);
  localparam int unsigned CW = $clog2(MAX_BOXES + 1);

  cnms_pkg::state_e state_q, state_d;

  logic [CW-1:0]         cnt_q, cnt_d, n_q, n_d, i_q, i_d, j_q, j_d, rank_q, rank_d;
  logic [15:0]           si_q, si_d, thr_q;
  logic [IW-1:0]         ki_q, ki_d, jx_q, jx_d, pend_q, pend_d;
  logic                  pend_v_q, pend_v_d;
  cnms_pkg::box_t        boxi_q, boxi_d;
  logic [LABEL_BITS-1:0] labi_q, labi_d;
  logic                  res_v_q, res_v_d;
  cnms_pkg::out_t        res_q, res_d;

  logic                  ld_we;
  logic [IW-1:0]         sc_raddr, ord_raddr, ord_waddr, ent_raddr, flg_waddr;
  logic                  ord_we, flg_we, flg_wdata;
  logic [15:0]           sc_rdata;
  logic [IW-1:0]         ord_rdata;
  cnms_pkg::box_t        box_rdata, box_wdata;
  logic [LABEL_BITS-1:0] lab_rdata;
  logic                  flg_rdata;
  cnms_pkg::iou_ctl_t    iou_ctl;
  logic                  suppress;
  logic                  ranks_ahead;

  assign box_wdata = '{x_min: in_i.box_x_min, y_min: in_i.box_y_min,
                       x_max: in_i.box_x_max, y_max: in_i.box_y_max};
  assign ranks_ahead = (sc_rdata > si_q) || ((sc_rdata == si_q) && (j_q < i_q));

  // Next state and datapath registers.
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    n_d      = n_q;
    i_d      = i_q;
    j_d      = j_q;
    rank_d   = rank_q;
    si_d     = si_q;
    ki_d     = ki_q;
    jx_d     = jx_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    boxi_d   = boxi_q;
    labi_d   = labi_q;
    res_v_d  = 1'b0;
    res_d    = res_q;
    case (state_q)
      cnms_pkg::ST_LOAD: begin
        if (start) begin
          if (cnt_q < CW'(MAX_BOXES)) begin
            cnt_d = cnt_q + 1'b1;
          end
          if (in_i.last_box) begin
            n_d = cnt_d;
            i_d = '0;
            state_d = (cnt_d == '0) ? cnms_pkg::ST_FLUSH : cnms_pkg::ST_SI_RD;
          end
        end
      end
      cnms_pkg::ST_SI_RD: state_d = cnms_pkg::ST_SI_WT;
      cnms_pkg::ST_SI_WT: begin
        si_d    = sc_rdata;
        j_d     = '0;
        rank_d  = '0;
        state_d = cnms_pkg::ST_SJ_RD;
      end
      cnms_pkg::ST_SJ_RD: state_d = cnms_pkg::ST_SJ_CMP;
      cnms_pkg::ST_SJ_CMP: begin
        rank_d = rank_q + CW'(ranks_ahead);
        if (j_q + 1'b1 == n_q) begin
          state_d = cnms_pkg::ST_ORD_WR;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = cnms_pkg::ST_SJ_RD;
        end
      end
      cnms_pkg::ST_ORD_WR: begin
        if (i_q + 1'b1 == n_q) begin
          i_d     = '0;
          state_d = cnms_pkg::ST_A_RD;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = cnms_pkg::ST_SI_RD;
        end
      end
      cnms_pkg::ST_A_RD: state_d = cnms_pkg::ST_A_WT;
      cnms_pkg::ST_A_WT: begin
        ki_d    = ord_rdata;
        state_d = cnms_pkg::ST_I_RD;
      end
      cnms_pkg::ST_I_RD: state_d = cnms_pkg::ST_I_WT;
      cnms_pkg::ST_I_WT: begin
        if (flg_rdata) begin
          state_d = cnms_pkg::ST_NEXT_A;
        end else begin
          // The previous kept box is not the final one, so its beat goes out now.
          if (pend_v_q) begin
            res_v_d = 1'b1;
            res_d   = '{kept_index: 6'(pend_q), last_kept: 1'b0};
          end
          pend_d   = ki_q;
          pend_v_d = 1'b1;
          boxi_d   = box_rdata;
          labi_d   = lab_rdata;
          j_d      = i_q + 1'b1;
          state_d  = (i_q + 1'b1 == n_q) ? cnms_pkg::ST_NEXT_A : cnms_pkg::ST_B_RD;
        end
      end
      cnms_pkg::ST_B_RD: state_d = cnms_pkg::ST_B_WT;
      cnms_pkg::ST_B_WT: begin
        jx_d    = ord_rdata;
        state_d = cnms_pkg::ST_J_RD;
      end
      cnms_pkg::ST_J_RD: state_d = cnms_pkg::ST_J_WT;
      cnms_pkg::ST_J_WT: begin
        if (flg_rdata || (lab_rdata != labi_q)) begin
          state_d = cnms_pkg::ST_NEXT_B;
        end else begin
          state_d = cnms_pkg::ST_C1;
        end
      end
      cnms_pkg::ST_C1: state_d = cnms_pkg::ST_C2;
      cnms_pkg::ST_C2: state_d = cnms_pkg::ST_C3;
      cnms_pkg::ST_C3: state_d = cnms_pkg::ST_NEXT_B;
      cnms_pkg::ST_NEXT_B: begin
        if (j_q + 1'b1 == n_q) begin
          state_d = cnms_pkg::ST_NEXT_A;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = cnms_pkg::ST_B_RD;
        end
      end
      cnms_pkg::ST_NEXT_A: begin
        if (i_q + 1'b1 == n_q) begin
          state_d = cnms_pkg::ST_FLUSH;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = cnms_pkg::ST_A_RD;
        end
      end
      cnms_pkg::ST_FLUSH: begin
        if (pend_v_q) begin
          res_v_d = 1'b1;
          res_d   = '{kept_index: 6'(pend_q), last_kept: 1'b1};
        end
        pend_v_d = 1'b0;
        cnt_d    = '0;
        state_d  = cnms_pkg::ST_LOAD;
      end
      default: state_d = cnms_pkg::ST_LOAD;
    endcase
  end

  // Memory ports and IoU unit controls.
  always_comb begin
    ld_we     = (state_q == cnms_pkg::ST_LOAD) && start && (cnt_q < CW'(MAX_BOXES));
    sc_raddr  = (state_q == cnms_pkg::ST_SJ_RD) ? j_q[IW-1:0] : i_q[IW-1:0];
    ord_raddr = (state_q == cnms_pkg::ST_B_RD) ? j_q[IW-1:0] : i_q[IW-1:0];
    ord_we    = (state_q == cnms_pkg::ST_ORD_WR);
    ord_waddr = rank_q[IW-1:0];
    ent_raddr = (state_q == cnms_pkg::ST_J_RD) ? jx_q : ki_q;
    flg_we    = ld_we || ((state_q == cnms_pkg::ST_C3) && suppress);
    flg_waddr = ld_we ? cnt_q[IW-1:0] : jx_q;
    flg_wdata = !ld_we;
    iou_ctl.ld_ext = (state_q == cnms_pkg::ST_J_WT) && !flg_rdata && (lab_rdata == labi_q);
    iou_ctl.ld_mul = (state_q == cnms_pkg::ST_C1);
    iou_ctl.ld_uni = (state_q == cnms_pkg::ST_C2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= cnms_pkg::ST_LOAD;
      cnt_q    <= '0;
      pend_v_q <= 1'b0;
      res_v_q  <= 1'b0;
      thr_q    <= cnms_pkg::IouThrReset;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      pend_v_q <= pend_v_d;
      res_v_q  <= res_v_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    i_q    <= i_d;
    j_q    <= j_d;
    rank_q <= rank_d;
    si_q   <= si_d;
    ki_q   <= ki_d;
    jx_q   <= jx_d;
    pend_q <= pend_d;
    boxi_q <= boxi_d;
    labi_q <= labi_d;
    res_q  <= res_d;
  end

  cnms_ram #(.WIDTH(64), .DEPTH(MAX_BOXES)) u_box_ram (
    .clk_i, .we_i(ld_we), .waddr_i(cnt_q[IW-1:0]), .wdata_i(box_wdata),
    .raddr_i(ent_raddr), .rdata_o(box_rdata)
  );

  cnms_ram #(.WIDTH(16), .DEPTH(MAX_BOXES)) u_score_ram (
    .clk_i, .we_i(ld_we), .waddr_i(cnt_q[IW-1:0]), .wdata_i(in_i.score),
    .raddr_i(sc_raddr), .rdata_o(sc_rdata)
  );

  cnms_ram #(.WIDTH(LABEL_BITS), .DEPTH(MAX_BOXES)) u_label_ram (
    .clk_i, .we_i(ld_we), .waddr_i(cnt_q[IW-1:0]),
    .wdata_i(LABEL_BITS'(in_i.class_label)),
    .raddr_i(ent_raddr), .rdata_o(lab_rdata)
  );

  cnms_ram #(.WIDTH(IW), .DEPTH(MAX_BOXES)) u_order_ram (
    .clk_i, .we_i(ord_we), .waddr_i(ord_waddr), .wdata_i(i_q[IW-1:0]),
    .raddr_i(ord_raddr), .rdata_o(ord_rdata)
  );

  // Each flag is cleared when its box is loaded, so no clearing pass is needed.
  cnms_ram #(.WIDTH(1), .DEPTH(MAX_BOXES)) u_flag_ram (
    .clk_i, .we_i(flg_we), .waddr_i(flg_waddr), .wdata_i(flg_wdata),
    .raddr_i(ent_raddr), .rdata_o(flg_rdata)
  );

  cnms_iou u_iou (
    .clk_i, .ctl_i(iou_ctl), .box_a_i(boxi_q), .box_b_i(box_rdata),
    .thr_i(thr_q), .suppress_o(suppress)
  );

  assign busy           = (state_q != cnms_pkg::ST_LOAD);
  assign result_valid_o = res_v_q;
  assign result_o       = res_q;

endmodule
